[hdl/slist_pkg.sv]
// ---------------------------------------------------------------------------
// slist_pkg: shared types and constants for the sorted list store
// Item layouts, mode and status codes, and sizing of the cell chain.
// ---------------------------------------------------------------------------
package slist_pkg;

    localparam int DEPTH   = 16;
    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int VAL_W   = 32;

    localparam logic [1:0] MODE_FILL    = 2'd0;
    localparam logic [1:0] MODE_INSERT  = 2'd1;
    localparam logic [1:0] MODE_DISPLAY = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]              mode;
        logic signed [VAL_W-1:0] new_value;
        logic                    restart;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] out_value;
        logic [1:0]              status;
        logic                    last;
    } t_out_item;

    // handed from each cell to its right neighbor
    typedef struct packed {
        logic                    after;
        logic signed [VAL_W-1:0] value;
    } t_link;

endpackage

[hdl/sorted_list_insert.sv]
// ---------------------------------------------------------------------------
// sorted_list_insert: ascending sorted store of signed 32-bit values
// A chain of DEPTH cells places fill/insert values in parallel; display
// streams the stored values out in order.
//
//   channel | signals                          | item
//   in      | i_in_valid, o_in_stall, i_in_item | t_in_item
//   out     | o_out_valid, i_out_stall, o_out_item | t_out_item
//
// For fill and insert items every cell compares in parallel and the chain
// shifts by one. Display streams the stored values through the single
// output register, holding while the output stalls; input stalls until
// the last entry is loaded.
// Reset empties the store at once. Output stalls back up into the input.
// ---------------------------------------------------------------------------
module sorted_list_insert
    import slist_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_item,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_item,
    input  logic      i_out_stall
);

    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic               r_disp;
    logic               n_disp;
    logic [IDX_W-1:0]   r_idx;
    logic [IDX_W-1:0]   n_idx;
    logic               r_out_valid;
    logic               n_out_valid;
    t_out_item          r_out;
    t_out_item          n_out;

    logic               w_out_free;
    logic               w_accept;
    logic               w_load;
    logic [COUNT_W-1:0] w_eff_count;
    logic               w_disp_last;
    t_link              w_link [DEPTH];

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_disp || !w_out_free;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_eff_count = (i_in_item.mode == MODE_FILL && i_in_item.restart)
                         ? '0 : r_count;

    assign w_load = w_accept && (w_eff_count != COUNT_W'(DEPTH)) &&
                    ((i_in_item.mode == MODE_FILL) ||
                     (i_in_item.mode == MODE_INSERT && r_count != '0));

    genvar k;
    generate
        for (k = 0; k < DEPTH; k++) begin : g_cell
            t_link w_prev;
            if (k == 0) begin : g_head
                assign w_prev = '{after: 1'b0, value: '0};
            end else begin : g_body
                assign w_prev = w_link[k-1];
            end
            slist_cell u_cell (
                .i_clk       (i_clk),
                .i_load      (w_load),
                .i_new_value (i_in_item.new_value),
                .i_occupied  (COUNT_W'(k) < w_eff_count),
                .i_prev      (w_prev),
                .o_link      (w_link[k])
            );
        end
    endgenerate

    assign w_disp_last = ({1'b0, r_idx} + COUNT_W'(1)) == r_count;

    always_comb begin
        n_count     = r_count;
        n_disp      = r_disp;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        if (r_disp && w_out_free) begin
            n_out_valid     = 1'b1;
            n_out.out_value = w_link[r_idx].value;
            n_out.status    = ST_OK;
            n_out.last      = w_disp_last;
            n_idx           = r_idx + IDX_W'(1);
            if (w_disp_last) begin
                n_disp = 1'b0;
            end
        end else if (w_accept) begin
            n_out.out_value = '0;
            n_out.last      = 1'b1;
            n_out.status    = ST_OK;
            unique case (i_in_item.mode)
                MODE_FILL, MODE_INSERT: begin
                    n_out_valid = 1'b1;
                    if (i_in_item.mode == MODE_INSERT && r_count == '0) begin
                        n_out.status = ST_EMPTY;
                    end else if (w_eff_count == COUNT_W'(DEPTH)) begin
                        n_out.status = ST_FULL;
                        n_count      = w_eff_count;
                    end else begin
                        n_count = w_eff_count + COUNT_W'(1);
                    end
                end
                MODE_DISPLAY: begin
                    if (r_count == '0) begin
                        n_out_valid  = 1'b1;
                        n_out.status = ST_EMPTY;
                    end else begin
                        n_disp = 1'b1;
                        n_idx  = '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_disp      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_disp      <= n_disp;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

[hdl/slist_cell.sv]
// ---------------------------------------------------------------------------
// slist_cell: one entry of the sorted chain
// Compares its value with the new value and either keeps it, takes the new
// value, or takes its left neighbor's value when an insert shifts the chain.
// ---------------------------------------------------------------------------
module slist_cell
    import slist_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_load,
    input  logic signed [VAL_W-1:0] i_new_value,
    input  logic                    i_occupied,
    input  t_link                   i_prev,
    output t_link                   o_link
);

    logic signed [VAL_W-1:0] r_value;
    logic signed [VAL_W-1:0] n_value;
    logic                    w_after;

    // entry sorts after the new value (free entries always do)
    assign w_after = !i_occupied || (r_value > i_new_value);

    always_comb begin
        n_value = r_value;
        if (i_load && w_after) begin
            if (i_prev.after) begin
                n_value = i_prev.value;
            end else begin
                n_value = i_new_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_link.after = w_after;
    assign o_link.value = r_value;

endmodule
